/* rtl/gfba_pkg.sv */
// ----------------------------------------------------------------------------
// gfba_pkg
// Shared constants, codes and types for the grouped free block allocator.
// ----------------------------------------------------------------------------
package gfba_pkg;

    localparam int FREE_SLOTS_DEF  = 64;
    localparam int BLOCK_COUNT_DEF = 256;

    localparam int BLOCK_W  = 8;
    localparam int STATUS_W = 2;

    // Request operations.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED  = 2'd2;

    typedef logic [BLOCK_W-1:0] t_block;

    // Per-cycle command to every cell of the slot chain.
    typedef struct packed {
        logic shift_in;
        logic shift_out;
    } t_cell_ctl;

endpackage

/* rtl/gfba_if.sv */
// ----------------------------------------------------------------------------
// gfba_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface gfba_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [gfba_pkg::BLOCK_W-1:0] block_number;

    modport source (output valid, output func, output block_number, input ready);
    modport sink   (input valid, input func, input block_number, output ready);
endinterface

interface gfba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [gfba_pkg::BLOCK_W-1:0]  granted_block;
    logic [gfba_pkg::STATUS_W-1:0] status;
    logic                         table_modified;

    modport source (output valid, output granted_block, output status,
                    output table_modified, input ready);
    modport sink   (input valid, input granted_block, input status,
                    input table_modified, output ready);
endinterface

/* rtl/gfba_ram.sv */
// ----------------------------------------------------------------------------
// gfba_ram
// Generic single-port RAM with one read per cycle plus a write when enabled, registered read.
// ----------------------------------------------------------------------------
module gfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gfba_cell.sv */
// ----------------------------------------------------------------------------
// gfba_cell
// One slot of the free block stack; shifts towards or away from the top.
// ----------------------------------------------------------------------------
module gfba_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gfba_pkg::t_cell_ctl i_ctl,
    input  gfba_pkg::t_block    i_from_top,
    input  gfba_pkg::t_block    i_from_bottom,
    output gfba_pkg::t_block    o_slot
);

    gfba_pkg::t_block r_slot;
    gfba_pkg::t_block n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.shift_in) begin
            n_slot = i_from_top;
        end else if (i_ctl.shift_out) begin
            n_slot = i_from_bottom;
        end
    end

    // The top cell holds the end-of-chain sentinel after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

/* rtl/grouped_free_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_core
// Grouped free list block allocator: a chain of slot cells holds the stack of
// free block numbers, and full groups are chained through the block store.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                    handshake
//  i_req    in         func, block_number                         valid/ready
//  o_rsp    out        granted_block, status, table_modified      valid/ready
//
// An ordinary allocate, free or refused request is taken when valid meets ready, and
// its response appears in the output register on the next cycle; requests may follow
// one per cycle while responses are taken. A free into a full stack spills the
// group to the block store; an allocate of the last group block refills from
// the store. Both use the single store port, and no request is taken until they
// finish. Reset is synchronous and leaves one empty group whose sentinel ends
// the chain. A stalled response blocks the next request.
module grouped_free_block_allocator_core #(
    parameter int FREE_SLOTS  = gfba_pkg::FREE_SLOTS_DEF,
    parameter int BLOCK_COUNT = gfba_pkg::BLOCK_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gfba_req_if.sink   i_req,
    gfba_rsp_if.source o_rsp
);

    localparam int IMAGE_WORDS   = FREE_SLOTS + 1;
    localparam int STORED_BLOCKS = (BLOCK_COUNT < 256) ? BLOCK_COUNT : 256;
    localparam int RAM_DEPTH     = STORED_BLOCKS * IMAGE_WORDS;
    localparam int ADDR_W        = $clog2(RAM_DEPTH);
    localparam int CNT_W         = $clog2(FREE_SLOTS + 1);
    localparam int WCNT_W        = $clog2(FREE_SLOTS + 2);
    localparam int WORD_W        = (CNT_W > gfba_pkg::BLOCK_W) ? CNT_W : gfba_pkg::BLOCK_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SPILL   = 3'd1;
    localparam logic [2:0] S_RF_HEAD = 3'd2;
    localparam logic [2:0] S_RF_CNT  = 3'd3;
    localparam logic [2:0] S_RF_DATA = 3'd4;

    logic [2:0]                    r_state,    n_state;
    logic [CNT_W-1:0]              r_count,    n_count;
    logic [WCNT_W-1:0]             r_word,     n_word;
    logic [CNT_W-1:0]              r_left,     n_left;
    logic [ADDR_W-1:0]             r_base,     n_base;
    gfba_pkg::t_block              r_blk,      n_blk;
    logic                          r_mod,      n_mod;
    logic                          r_out_valid, n_out_valid;
    gfba_pkg::t_block              r_granted,  n_granted;
    logic [gfba_pkg::STATUS_W-1:0] r_status,   n_status;
    logic                          r_out_mod,  n_out_mod;

    gfba_pkg::t_block    w_slot [FREE_SLOTS];
    gfba_pkg::t_cell_ctl w_ctl;
    gfba_pkg::t_block    w_head_in;
    gfba_pkg::t_block    w_base_src;
    logic [ADDR_W-1:0]   w_base_prod;
    logic                w_accept;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_addr;
    logic [WORD_W-1:0]   w_ram_wdata;
    logic [WORD_W-1:0]   w_ram_rdata;
    logic [CNT_W-1:0]    w_img_cnt;

    assign i_req.ready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    // An allocate reloads from the image of the block in the top slot; a free spills
    // into the image of the block being freed.
    assign w_base_src  = (i_req.func == gfba_pkg::FUNC_ALLOC) ? w_slot[0]
                                                               : i_req.block_number;
    assign w_base_prod = ADDR_W'(32'(w_base_src) * 32'(IMAGE_WORDS));
    assign w_ram_addr  = r_base + ADDR_W'(r_word);

    // A count word beyond the stack depth is clamped to a full stack.
    assign w_img_cnt = (w_ram_rdata > WORD_W'(FREE_SLOTS)) ? CNT_W'(FREE_SLOTS)
                                                            : w_ram_rdata[CNT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_word      = r_word;
        n_left      = r_left;
        n_base      = r_base;
        n_blk       = r_blk;
        n_mod       = r_mod;
        n_out_valid = r_out_valid;
        n_granted   = r_granted;
        n_status    = r_status;
        n_out_mod   = r_out_mod;
        w_ctl       = '0;
        w_head_in   = i_req.block_number;
        w_ram_we    = 1'b0;
        w_ram_wdata = WORD_W'(w_slot[0]);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_granted   = '0;
                    n_status    = gfba_pkg::STATUS_DONE;
                    if (i_req.func == gfba_pkg::FUNC_ALLOC) begin
                        if (r_count > CNT_W'(1)) begin
                            n_granted       = w_slot[0];
                            w_ctl.shift_out = 1'b1;
                            n_count         = r_count - CNT_W'(1);
                            n_mod           = 1'b1;
                        end else if ((r_count == CNT_W'(1)) && (w_slot[0] != '0)) begin
                            // Last block of the group: grant it and reload its image.
                            n_granted  = w_slot[0];
                            n_base     = w_base_prod;
                            n_word     = '0;
                            n_count    = '0;
                            n_mod      = 1'b1;
                            n_state    = S_RF_HEAD;
                        end else begin
                            n_status = gfba_pkg::STATUS_NO_SPACE;
                        end
                    end else begin
                        if ((i_req.block_number == '0) ||
                            (32'(i_req.block_number) >= BLOCK_COUNT)) begin
                            n_status = gfba_pkg::STATUS_REFUSED;
                        end else if (r_count < CNT_W'(FREE_SLOTS)) begin
                            w_ctl.shift_in = 1'b1;
                            n_count        = r_count + CNT_W'(1);
                            n_mod          = 1'b1;
                        end else begin
                            n_base  = w_base_prod;
                            n_blk   = i_req.block_number;
                            n_word  = WCNT_W'(FREE_SLOTS);
                            n_mod   = 1'b1;
                            n_state = S_SPILL;
                        end
                    end
                    n_out_mod = n_mod;
                end
            end
            S_SPILL: begin
                // The top slot goes to the highest image word first; the count
                // word is written last, and the freed block starts a new group.
                w_ram_we = 1'b1;
                if (r_word == '0) begin
                    w_ram_wdata    = WORD_W'(FREE_SLOTS);
                    w_head_in      = r_blk;
                    w_ctl.shift_in = 1'b1;
                    n_count        = CNT_W'(1);
                    n_state        = S_IDLE;
                end else begin
                    w_ctl.shift_out = 1'b1;
                    n_word          = r_word - WCNT_W'(1);
                end
            end
            S_RF_HEAD: begin
                n_word  = WCNT_W'(1);
                n_state = S_RF_CNT;
            end
            S_RF_CNT: begin
                if (w_img_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_left  = w_img_cnt;
                    n_word  = r_word + WCNT_W'(1);
                    n_state = S_RF_DATA;
                end
            end
            S_RF_DATA: begin
                // Image words arrive bottom first, so the last one lands on top.
                w_head_in      = w_ram_rdata[gfba_pkg::BLOCK_W-1:0];
                w_ctl.shift_in = 1'b1;
                n_count        = r_count + CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_left = r_left - CNT_W'(1);
                    n_word = r_word + WCNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_mod       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mod       <= n_mod;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_left    <= n_left;
        r_base    <= n_base;
        r_blk     <= n_blk;
        r_granted <= n_granted;
        r_status  <= n_status;
        r_out_mod <= n_out_mod;
    end

    for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
        gfba_pkg::t_block w_from_top;
        gfba_pkg::t_block w_from_bottom;

        if (g == 0) begin : g_top
            assign w_from_top = w_head_in;
        end else begin : g_inner
            assign w_from_top = w_slot[g-1];
        end

        if (g == FREE_SLOTS - 1) begin : g_last
            assign w_from_bottom = '0;
        end else begin : g_more
            assign w_from_bottom = w_slot[g+1];
        end

        gfba_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_from_top    (w_from_top),
            .i_from_bottom (w_from_bottom),
            .o_slot        (w_slot[g])
        );
    end

    gfba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.granted_block  = r_granted;
    assign o_rsp.status         = r_status;
    assign o_rsp.table_modified = r_out_mod;

endmodule

/* rtl/gfba_checker.sv */
// ----------------------------------------------------------------------------
// gfba_checker
// Port-level checks on request/response ordering and response contents.
// ----------------------------------------------------------------------------
module gfba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [gfba_pkg::BLOCK_W-1:0]  i_rsp_granted_block,
    input logic [gfba_pkg::STATUS_W-1:0] i_rsp_status,
    input logic                          i_rsp_table_modified
);

    // Every accepted request has its response valid on the next cycle.
    a_rsp_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> i_rsp_valid)
        else $error("no response after an accepted request");

    // A response that is held back blocks further requests.
    a_no_req_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !(i_req_valid && i_req_ready))
        else $error("request accepted while a response was stalled");

    // Only a successful request can name a block; a failed one reports block zero.
    a_grant_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != gfba_pkg::STATUS_DONE))
            |-> (i_rsp_granted_block == '0))
        else $error("block granted on a failed request");

    // Once reported, the modified flag stays set.
    a_modified_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_ready && i_rsp_table_modified)
            |=> (!i_rsp_valid || i_rsp_table_modified))
        else $error("table modified flag cleared");

endmodule

bind grouped_free_block_allocator_core gfba_checker u_gfba_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_granted_block  (o_rsp.granted_block),
    .i_rsp_status         (o_rsp.status),
    .i_rsp_table_modified (o_rsp.table_modified)
);

/* bench/grouped_free_block_allocator_core_test.sv */
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_core_test
// Self-checking bench for the grouped free list allocator. Allocate and free
// requests go in over the request channel and a behavioural copy of the
// allocator state predicts every response. Runs cover the empty list and its
// sentinel, refused frees, double frees, and long free/allocate sequences that
// spill groups to the block store and refill from it, under varied idling on
// both channels.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator_core_test;

    localparam int FREE_SLOTS    = gfba_pkg::FREE_SLOTS_DEF;
    localparam int BLOCK_COUNT   = gfba_pkg::BLOCK_COUNT_DEF;
    localparam int IMAGE_WORDS   = FREE_SLOTS + 1;
    localparam int SETTLE_CYCLES = 2 * FREE_SLOTS + 20;

    typedef struct packed {
        gfba_pkg::t_block              granted_block;
        logic [gfba_pkg::STATUS_W-1:0] status;
        logic                          table_modified;
    } t_alloc_response;

    logic clk;
    logic rst_n;

    gfba_req_if req_ch ();
    gfba_rsp_if rsp_ch ();

    grouped_free_block_allocator_core #(
        .FREE_SLOTS  (FREE_SLOTS),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted allocator state.
    gfba_pkg::t_block free_stack [FREE_SLOTS];
    int unsigned      free_count;
    gfba_pkg::t_block group_images [BLOCK_COUNT][IMAGE_WORDS];
    logic             list_changed;
    t_alloc_response  pending_responses [$];

    int fail_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_cycles_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("grouped_free_block_allocator_core regression: fail");
        $finish;
    end

    function automatic void clear_allocator_state();
        foreach (free_stack[i]) free_stack[i] = '0;
        foreach (group_images[b, w]) group_images[b][w] = '0;
        free_count   = 1;
        list_changed = 1'b0;
    endfunction

    function automatic void predict_allocation(logic func, gfba_pkg::t_block blk);
        t_alloc_response  resp;
        gfba_pkg::t_block source_block;
        int unsigned      group_size;
        resp = '{granted_block: '0, status: gfba_pkg::STATUS_DONE, table_modified: 1'b0};
        if (func == gfba_pkg::FUNC_ALLOC) begin
            if (free_count > 1) begin
                free_count--;
                if (free_count >= FREE_SLOTS) free_count = FREE_SLOTS - 1;
                resp.granted_block = free_stack[free_count];
                list_changed = 1'b1;
            end else if (free_count == 1 && free_stack[0] != '0) begin
                // Last block of the group: it is granted and its image becomes the stack.
                source_block = free_stack[0];
                group_size   = group_images[source_block][0];
                if (group_size > FREE_SLOTS) group_size = FREE_SLOTS;
                for (int i = 0; i < FREE_SLOTS; i++)
                    free_stack[i] = group_images[source_block][i + 1];
                free_count = group_size;
                resp.granted_block = source_block;
                list_changed = 1'b1;
            end else begin
                resp.status = gfba_pkg::STATUS_NO_SPACE;
            end
        end else if (blk == '0 || int'(blk) >= BLOCK_COUNT) begin
            resp.status = gfba_pkg::STATUS_REFUSED;
        end else begin
            if (free_count < FREE_SLOTS) begin
                free_stack[free_count] = blk;
                free_count++;
            end else begin
                // A full stack is written into the freed block, which then heads the chain.
                group_images[blk][0] = gfba_pkg::t_block'(free_count);
                for (int i = 0; i < FREE_SLOTS; i++)
                    group_images[blk][i + 1] = free_stack[i];
                free_count    = 1;
                free_stack[0] = blk;
            end
            list_changed = 1'b1;
        end
        resp.table_modified = list_changed;
        pending_responses.push_back(resp);
    endfunction

    // Called just after a rising edge; leaves valid high so that back-to-back
    // requests need no second assignment in one step.
    task automatic send_request(logic func, gfba_pkg::t_block blk);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= func;
        req_ch.block_number <= blk;
        do @(posedge clk); while (!req_ch.ready);
        predict_allocation(func, blk);
    endtask

    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_responses.size() != 0);
    endtask

    task automatic run_request_mix(int count, int free_pct);
        for (int k = 0; k < count; k++) begin
            logic             func;
            gfba_pkg::t_block blk;
            func = ($urandom_range(99) < free_pct) ? gfba_pkg::FUNC_FREE
                                                   : gfba_pkg::FUNC_ALLOC;
            blk  = ($urandom_range(99) < 3) ? gfba_pkg::t_block'(0)
                   : gfba_pkg::t_block'($urandom_range(BLOCK_COUNT - 1, 1));
            send_request(func, blk);
        end
    endtask

    // Mostly frees to build a chain of several groups, then mostly allocates
    // to walk it back down to the sentinel.
    task automatic build_and_drain_chain(int fill_count, int drain_count);
        run_request_mix(fill_count, 80);
        run_request_mix(drain_count, 20);
    endtask

    task automatic test_directed_edges();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_request(gfba_pkg::FUNC_ALLOC, 8'hFF);
        send_request(gfba_pkg::FUNC_FREE, 8'h00);
        send_request(gfba_pkg::FUNC_FREE, 8'hFF);
        send_request(gfba_pkg::FUNC_FREE, 8'h01);
        send_request(gfba_pkg::FUNC_FREE, 8'h80);
        send_request(gfba_pkg::FUNC_FREE, 8'hAA);
        send_request(gfba_pkg::FUNC_FREE, 8'h55);
        repeat (5) send_request(gfba_pkg::FUNC_ALLOC, 8'h00);
        send_request(gfba_pkg::FUNC_ALLOC, 8'hFF);
        // A double free is not detected, so the block comes back twice.
        send_request(gfba_pkg::FUNC_FREE, 8'h09);
        send_request(gfba_pkg::FUNC_FREE, 8'h09);
        repeat (3) send_request(gfba_pkg::FUNC_ALLOC, 8'h7F);
        send_request(gfba_pkg::FUNC_FREE, 8'h00);
    endtask

    task automatic test_chain_no_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        build_and_drain_chain(250, 300);
    endtask

    task automatic test_chain_sender_idle();
        sender_idle_pct    = 75;
        receiver_stall_pct = 0;
        build_and_drain_chain(150, 200);
    endtask

    task automatic test_chain_receiver_stall();
        sender_idle_pct    = 0;
        receiver_stall_pct = 75;
        build_and_drain_chain(150, 200);
    endtask

    task automatic test_chain_both_idle();
        sender_idle_pct    = 25;
        receiver_stall_pct = 25;
        build_and_drain_chain(150, 200);
    endtask

    task automatic test_output_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles_left   = 300;
        run_request_mix(120, 50);
        wait_for_responses();
        run_request_mix(60, 50);
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_cycles_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_alloc_response want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_responses.size() == 0) begin
                $error("response with none expected: granted_block %0d status %0d",
                       rsp_ch.granted_block, rsp_ch.status);
                fail_count++;
            end else begin
                want = pending_responses.pop_front();
                if (rsp_ch.granted_block !== want.granted_block) begin
                    $error("granted_block: expected %0d, got %0d",
                           want.granted_block, rsp_ch.granted_block);
                    fail_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.table_modified !== want.table_modified) begin
                    $error("table_modified: expected %0d, got %0d",
                           want.table_modified, rsp_ch.table_modified);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= gfba_pkg::FUNC_ALLOC;
        req_ch.block_number <= '0;
        fail_count          = 0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        hold_cycles_left    = 0;
        clear_allocator_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_chain_no_idle();
        test_chain_sender_idle();
        test_chain_receiver_stall();
        test_chain_both_idle();
        test_output_hold_off();

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_responses.size() != 0) begin
            $error("%0d responses never arrived", pending_responses.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("grouped_free_block_allocator_core regression: pass");
        end else begin
            $display("grouped_free_block_allocator_core regression: fail");
        end
        $finish;
    end

endmodule
